// ===== hdl/stt_pkg.sv =====
package stt_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int MAX_OUT   = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN_W    = $clog2(SLOTS + 1);
  localparam int BUF_W     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int BUF_CNT_W = $clog2(MAX_OUT + 1);

  // Field widths
  localparam int TIME_W  = 48;
  localparam int DELAY_W = 32;
  localparam int ID_W    = 16;
  localparam int IDX_W   = 4;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_NOT_FOUND   = 2'd2,
    STAT_NOTHING_DUE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND,
    ST_DRAIN
  } state_t;

  // Classified request, as it travels through the queue
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] time_val;
    logic              periodic;
    logic [ID_W-1:0]   id;
  } cmd_t;

  // One timer slot in the entry memory
  typedef struct packed {
    logic              periodic;
    logic [TIME_W-1:0] time_val;
    logic [TIME_W-1:0] last_fire;
    logic [ID_W-1:0]   ident;
  } entry_t;

  // One firing, held until the tick's scan is over
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
  } fire_t;

  // Report a slot number in the fixed width of the result field
  function automatic logic [IDX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, s};
    return wide[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/stt_front.sv =====
module stt_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stt_pkg::REQ_W-1:0]    req_type,
  input  logic [stt_pkg::TIME_W-1:0]   now_ms,
  input  logic [stt_pkg::DELAY_W-1:0]  delay_ms,
  input  logic                         repeat_flag,
  input  logic [stt_pkg::ID_W-1:0]     event_id,
  output logic                         push_valid,
  input  logic                         push_stall,
  output stt_pkg::cmd_t                push_cmd
);
  import stt_pkg::*;

  logic [TIME_W-1:0] period_ext;
  logic [TIME_W-1:0] deadline;

  // Hold the sender while the queue is full
  assign in_stall   = push_stall;
  assign push_valid = in_valid;

  // Work out the one-shot deadline up front, wrapping at 48 bits
  assign period_ext = {{(TIME_W-DELAY_W){1'b0}}, delay_ms};
  assign deadline   = now_ms + period_ext;

  // Classify the request
  always_comb begin
    push_cmd.now      = now_ms;
    push_cmd.periodic = repeat_flag;
    push_cmd.id       = event_id;
    push_cmd.time_val = repeat_flag ? period_ext : deadline;
    case (req_type)
      REQ_ADD:    push_cmd.op = OP_ADD;
      REQ_REMOVE: push_cmd.op = OP_REMOVE;
      REQ_TICK:   push_cmd.op = OP_TICK;
      default:    push_cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/stt_queue.sv =====
module stt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  stt_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output stt_pkg::cmd_t pop_cmd
);
  import stt_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_fire;
  logic              pop_fire;

  assign push_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && !push_stall;
  assign pop_fire   = pop && pop_valid;
  assign pop_cmd    = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop_fire)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push_fire) - QCNT_W'(pop_fire);
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push_fire) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ===== hdl/stt_back.sv =====
module stt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  stt_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stt_pkg::STAT_W-1:0]  status,
  output logic                        fired,
  output logic [stt_pkg::ID_W-1:0]    fired_id,
  output logic [stt_pkg::IDX_W-1:0]   slot_index,
  output logic                        table_empty,
  output logic                        last_result
);
  import stt_pkg::*;

  state_t               state;
  state_t               state_next;
  cmd_t                 cmd;
  logic [SLOTS-1:0]     slot_valid;
  logic [SLOTS-1:0]     slot_valid_next;

  entry_t               mem [SLOTS];
  entry_t               mem_rd;
  entry_t               mem_wdata;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [SLOT_W-1:0]    mem_raddr;

  logic [SCAN_W-1:0]    scan_idx;
  logic                 scan_issue;
  logic                 scan_done;
  logic                 eval_valid;
  logic [SLOT_W-1:0]    eval_idx;

  fire_t                fire_buf [MAX_OUT];
  fire_t                drain_entry;
  logic [BUF_CNT_W-1:0] fire_cnt;
  logic [BUF_CNT_W-1:0] drain_ptr;
  logic                 drain_last;

  status_t              res_status;
  logic [ID_W-1:0]      res_id;
  logic [SLOT_W-1:0]    res_slot;

  logic                 free_any;
  logic [SLOT_W-1:0]    free_slot;
  logic                 add_go;
  logic [TIME_W-1:0]    elapsed;
  logic                 due;
  logic                 tick_fire;
  logic                 rm_hit;
  logic                 out_free;
  logic                 load_single;
  logic                 load_drain;

  assign out_free = !out_valid || !out_stall;

  // Find the lowest free slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign add_go = (state == ST_IDLE) && q_valid && (q_cmd.op == OP_ADD) && free_any;

  // Judge the slot whose entry came out of memory this cycle
  assign elapsed   = cmd.now - mem_rd.last_fire;
  assign due       = mem_rd.periodic ? (elapsed >= mem_rd.time_val)
                                     : (cmd.now >= mem_rd.time_val);
  assign tick_fire = eval_valid && (cmd.op == OP_TICK) && slot_valid[eval_idx] && due
                     && (fire_cnt < BUF_CNT_W'(MAX_OUT));
  assign rm_hit    = eval_valid && (cmd.op == OP_REMOVE) && slot_valid[eval_idx]
                     && (mem_rd.ident == cmd.id) && (res_status != STAT_OK);

  assign scan_done  = (state == ST_SCAN) && !scan_issue && !eval_valid;
  assign drain_last = ((drain_ptr + BUF_CNT_W'(1)) == fire_cnt);
  assign drain_entry = fire_buf[drain_ptr[BUF_W-1:0]];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_REMOVE || q_cmd.op == OP_TICK) state_next = ST_SCAN;
          else state_next = ST_SEND;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (cmd.op == OP_TICK && fire_cnt != '0) state_next = ST_DRAIN;
          else state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_DRAIN: begin
        if (out_free && drain_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop       = 1'b0;
    scan_issue  = 1'b0;
    load_single = 1'b0;
    load_drain  = 1'b0;
    case (state)
      ST_IDLE:  q_pop = 1'b1;
      ST_SCAN:  scan_issue = (scan_idx < SCAN_W'(SLOTS));
      ST_SEND:  load_single = out_free;
      ST_DRAIN: load_drain = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Select the memory write: a new timer, or a periodic timer's new firing time
  assign mem_raddr = scan_idx[SLOT_W-1:0];
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = eval_idx;
    mem_wdata = mem_rd;
    if (add_go) begin
      mem_we             = 1'b1;
      mem_waddr          = free_slot;
      mem_wdata.periodic = q_cmd.periodic;
      mem_wdata.time_val = q_cmd.time_val;
      mem_wdata.last_fire = q_cmd.now;
      mem_wdata.ident    = q_cmd.id;
    end else if (tick_fire && mem_rd.periodic) begin
      mem_we              = 1'b1;
      mem_wdata.last_fire = cmd.now;
    end
  end

  // Set on add, drop on remove or one-shot firing
  always_comb begin
    slot_valid_next = slot_valid;
    if (add_go) slot_valid_next[free_slot] = 1'b1;
    if (rm_hit) slot_valid_next[eval_idx] = 1'b0;
    if (tick_fire && !mem_rd.periodic) slot_valid_next[eval_idx] = 1'b0;
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rd <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      eval_valid <= 1'b0;
      scan_idx   <= '0;
      fire_cnt   <= '0;
      drain_ptr  <= '0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      eval_valid <= scan_issue;
      if (state == ST_IDLE) begin
        scan_idx  <= '0;
        fire_cnt  <= '0;
        drain_ptr <= '0;
      end else begin
        if (scan_issue) scan_idx  <= scan_idx + SCAN_W'(1);
        if (tick_fire)  fire_cnt  <= fire_cnt + BUF_CNT_W'(1);
        if (load_drain) drain_ptr <= drain_ptr + BUF_CNT_W'(1);
      end
    end
  end

  // Take the command, prepare its single result and buffer each tick firing
  always_ff @(posedge clk) begin
    eval_idx <= mem_raddr;
    if (state == ST_IDLE && q_valid) begin
      cmd <= q_cmd;
      case (q_cmd.op)
        OP_ADD: begin
          res_status <= free_any ? STAT_OK : STAT_FULL;
          res_id     <= q_cmd.id;
          res_slot   <= free_any ? free_slot : '0;
        end
        OP_REMOVE: begin
          res_status <= STAT_NOT_FOUND;
          res_id     <= q_cmd.id;
          res_slot   <= '0;
        end
        default: begin
          res_status <= STAT_NOTHING_DUE;
          res_id     <= '0;
          res_slot   <= '0;
        end
      endcase
    end else if (rm_hit) begin
      res_status <= STAT_OK;
      res_slot   <= eval_idx;
    end
    if (tick_fire) begin
      fire_buf[fire_cnt[BUF_W-1:0]] <= '{id: mem_rd.ident, slot: eval_idx};
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || load_drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_single) begin
      status      <= res_status;
      fired       <= 1'b0;
      fired_id    <= res_id;
      slot_index  <= slot_to_index(res_slot);
      table_empty <= ~|slot_valid;
      last_result <= 1'b1;
    end else if (load_drain) begin
      status      <= STAT_OK;
      fired       <= 1'b1;
      fired_id    <= drain_entry.id;
      slot_index  <= slot_to_index(drain_entry.slot);
      table_empty <= ~|slot_valid;
      last_result <= drain_last;
    end
  end

  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    eval_valid |-> state == ST_SCAN)
    else $error("slot evaluated outside a scan");

  a_drain_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> fire_cnt != '0 && drain_ptr < fire_cnt)
    else $error("drain without buffered firings");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= BUF_CNT_W'(MAX_OUT))
    else $error("firing buffer overrun");

  a_idle_leaves: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && q_valid |=> state != ST_IDLE)
    else $error("queued command not taken");

endmodule

// ===== hdl/software_timer_table_unit.sv =====
// Software timer table: SLOTS one-shot or periodic timers driven by requests
// that carry the current time.
// Input channel (in_valid/in_stall): req_type selects add, remove by id or
// tick; a transfer happens when in_valid is high and in_stall is low. A
// two-entry command queue sits behind the input, so in_stall rises only when
// it is full.
// Output channel (out_valid/out_stall): one result per add, remove or unused
// code; a tick gives one result per firing timer in slot order, or a single
// nothing-due result. last_result marks the final result of each request.
// Add gives its result without a scan; remove and tick scan the entry memory
// one slot per cycle before their first result. The back end takes one
// request at a time, and the entry memory has one read port; later requests
// wait in the queue.
// Reset (rst, synchronous) empties the table and the queue; entry contents
// need no clearing pass. While out_stall is high the result register holds,
// the back end waits to load a result and the queue backs up onto in_stall.
module software_timer_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stt_pkg::REQ_W-1:0]    req_type,
  input  logic [stt_pkg::TIME_W-1:0]   now_ms,
  input  logic [stt_pkg::DELAY_W-1:0]  delay_ms,
  input  logic                         repeat_flag,
  input  logic [stt_pkg::ID_W-1:0]     event_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stt_pkg::STAT_W-1:0]   status,
  output logic                         fired,
  output logic [stt_pkg::ID_W-1:0]     fired_id,
  output logic [stt_pkg::IDX_W-1:0]    slot_index,
  output logic                         table_empty,
  output logic                         last_result
);
  import stt_pkg::*;

  logic push_valid;
  logic push_stall;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  stt_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .now_ms      (now_ms),
    .delay_ms    (delay_ms),
    .repeat_flag (repeat_flag),
    .event_id    (event_id),
    .push_valid  (push_valid),
    .push_stall  (push_stall),
    .push_cmd    (push_cmd)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (pop_valid),
    .q_cmd       (pop_cmd),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .fired       (fired),
    .fired_id    (fired_id),
    .slot_index  (slot_index),
    .table_empty (table_empty),
    .last_result (last_result)
  );

endmodule
